// ===== design/timed_step_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timed step sequencer.
// ----------------------------------------------------------------------------
`ifndef TIMED_STEP_SEQUENCER_ASSERT_SVH
`define TIMED_STEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("timed step sequencer: same-cycle check failed");

// Next-cycle implication, off during reset.
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("timed step sequencer: next-cycle check failed");

`endif

// ===== design/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Types, codes and constants shared by the timed step sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int unsigned MAX_STEPS   = 16;
  localparam int unsigned RESULT_CAP  = 64;
  localparam int unsigned COUNT_W     = $clog2(RESULT_CAP + 1);
  localparam int unsigned STEP_CNT_W  = 5;
  localparam logic [7:0]  TARGET_MARK = 8'hFF;
  localparam logic [7:0]  LOOP_FOREVER = 8'hFF;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_PLAY   = 3'd2,
    OP_STOP   = 3'd3,
    OP_TARGET = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_ADVANCE
  } state_e;

  typedef enum logic {
    PH_CHECK,
    PH_ENTER
  } phase_e;

  typedef enum logic [1:0] {
    EMIT_STATUS,
    EMIT_SLOT,
    EMIT_TARGET
  } emit_e;

  typedef struct packed {
    logic [2:0]            operation;
    logic [31:0]           now_ms;
    logic [3:0]            step_index;
    logic [7:0]            step_pattern;
    logic [15:0]           step_trans_ms;
    logic [15:0]           step_hold_ms;
    logic [STEP_CNT_W-1:0] play_len;
    logic [7:0]            loop_limit;
    logic [7:0]            target_pattern;
  } item_t;

  typedef struct packed {
    logic       pattern_valid;
    logic [7:0] pattern;
    logic       playing;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]  pat;
    logic [15:0] trans;
    logic [15:0] hold;
  } step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  store_wr;
    logic  play_setup;
    logic  stop;
    logic  set_target;
    logic  rd;
    logic  enter;
    logic  advance;
    logic  emit;
    emit_e emit_kind;
    logic  last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       running;
    logic       play_ok;
    logic       slot_zero;
    logic       slot_due;
    logic       wrap;
    logic       pass_more;
    logic       cap_hit;
  } status_t;

endpackage

`default_nettype wire

// ===== design/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// tss_ctrl
// Controller state machine: decodes an item and walks the step chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl
  import tss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_CHECK;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_d = ST_IDLE;
        unique case (status_i.op)
          OP_TICK: begin
            if (status_i.running) begin
              phase_d = PH_CHECK;
              state_d = ST_READ;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
            end
          end
          OP_LOAD: begin
            cmd_o.store_wr = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.last     = 1'b1;
          end
          OP_PLAY: begin
            if (status_i.play_ok) begin
              cmd_o.play_setup = 1'b1;
              phase_d          = PH_ENTER;
              state_d          = ST_READ;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
            end
          end
          OP_STOP: begin
            cmd_o.stop = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
          end
          OP_TARGET: begin
            cmd_o.set_target = 1'b1;
            cmd_o.emit       = 1'b1;
            cmd_o.emit_kind  = EMIT_TARGET;
            cmd_o.last       = 1'b1;
          end
          default: begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
          end
        endcase
      end

      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end

      ST_EVAL: begin
        if (phase_q == PH_ENTER) begin
          // The chain goes on only through a zero-length step below the result cap.
          cmd_o.enter     = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_SLOT;
          if (status_i.slot_zero && !status_i.cap_hit) begin
            state_d = ST_ADVANCE;
          end else begin
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (status_i.slot_zero || status_i.slot_due) begin
          state_d = ST_ADVANCE;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        if (status_i.wrap && !status_i.pass_more) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          phase_d = PH_ENTER;
          state_d = ST_READ;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tss_datapath.sv =====
// ----------------------------------------------------------------------------
// tss_datapath
// Step store, play state, elapsed-time compare and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_datapath
  import tss_pkg::*;
#(
  parameter int unsigned MaxSteps = MAX_STEPS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    valid_o,
  output result_t result_o
);

  // Slots above 15 cannot be addressed by a load, so the store stops there.
  localparam int unsigned StoreDepth = (MaxSteps < 16) ? MaxSteps : 16;
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  step_t mem [StoreDepth];
  step_t rdata_q;

  item_t                 item_q;
  logic [STEP_CNT_W-1:0] active_count_q;
  logic [7:0]            pass_limit_q;
  logic [7:0]            passes_done_q;
  logic [STEP_CNT_W-1:0] cur_step_q;
  logic [31:0]           start_ms_q;
  logic [31:0]           elapsed_q;
  logic [7:0]            target_q;
  logic                  running_q, running_d;
  logic [COUNT_W-1:0]    n_q;
  logic                  valid_q;
  result_t               result_q, result_d;

  logic                  load_ok;
  logic [16:0]           total;
  logic [STEP_CNT_W:0]   cur_inc;
  logic [7:0]            pass_inc;
  logic                  wrap;
  logic                  pass_more;
  logic [7:0]            slot_pat;

  assign load_ok   = (32'(item_q.step_index) < MaxSteps);
  assign total     = {1'b0, rdata_q.trans} + {1'b0, rdata_q.hold};
  assign cur_inc   = {1'b0, cur_step_q} + {{STEP_CNT_W{1'b0}}, 1'b1};
  assign pass_inc  = passes_done_q + 8'd1;
  assign wrap      = (cur_inc >= {1'b0, active_count_q});
  assign pass_more = (pass_limit_q == LOOP_FOREVER) || (pass_inc < pass_limit_q);
  assign slot_pat  = (rdata_q.pat == TARGET_MARK) ? target_q : rdata_q.pat;

  always_comb begin
    status_o.op        = item_q.operation;
    status_o.running   = running_q;
    status_o.play_ok   = (item_q.play_len != '0) && (32'(item_q.play_len) <= MaxSteps);
    status_o.slot_zero = (total == 17'd0);
    status_o.slot_due  = (elapsed_q >= 32'(total));
    status_o.wrap      = wrap;
    status_o.pass_more = pass_more;
    status_o.cap_hit   = (n_q >= COUNT_W'(RESULT_CAP - 1));
  end

  always_comb begin
    running_d = running_q;
    if (cmd_i.play_setup) begin
      running_d = 1'b1;
    end
    if (cmd_i.stop || cmd_i.set_target) begin
      running_d = 1'b0;
    end
    if (cmd_i.advance && wrap && !pass_more) begin
      running_d = 1'b0;
    end
  end

  always_comb begin
    result_d.pattern_valid = (cmd_i.emit_kind != EMIT_STATUS);
    unique case (cmd_i.emit_kind)
      EMIT_SLOT:   result_d.pattern = slot_pat;
      EMIT_TARGET: result_d.pattern = item_q.target_pattern;
      default:     result_d.pattern = 8'd0;
    endcase
    result_d.playing = running_d;
    result_d.last    = cmd_i.last;
  end

  // Step store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr && load_ok) begin
      mem[item_q.step_index[AddrW-1:0]] <= '{pat:   item_q.step_pattern,
                                             trans: item_q.step_trans_ms,
                                             hold:  item_q.step_hold_ms};
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[cur_step_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.rd) begin
      elapsed_q <= item_q.now_ms - start_ms_q;
    end
    if (cmd_i.emit) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      pass_limit_q   <= '0;
      passes_done_q  <= '0;
      cur_step_q     <= '0;
      start_ms_q     <= '0;
      target_q       <= '0;
      running_q      <= 1'b0;
      n_q            <= '0;
      valid_q        <= 1'b0;
    end else begin
      running_q <= running_d;
      valid_q   <= cmd_i.emit;
      if (cmd_i.capture) begin
        n_q <= '0;
      end else if (cmd_i.emit) begin
        n_q <= n_q + COUNT_W'(1);
      end
      if (cmd_i.play_setup) begin
        active_count_q <= item_q.play_len;
        pass_limit_q   <= item_q.loop_limit;
        passes_done_q  <= '0;
        cur_step_q     <= '0;
      end
      if (cmd_i.set_target) begin
        target_q <= item_q.target_pattern;
      end
      if (cmd_i.enter) begin
        start_ms_q <= item_q.now_ms;
      end
      if (cmd_i.advance) begin
        if (wrap) begin
          passes_done_q <= pass_inc;
          cur_step_q    <= '0;
        end else begin
          cur_step_q <= cur_inc[STEP_CNT_W-1:0];
        end
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== design/timed_step_sequencer.sv =====
// ----------------------------------------------------------------------------
// timed_step_sequencer
// Plays a stored list of timed pattern steps with pass counting.
// ----------------------------------------------------------------------------
//   Channel   Signals                 Transfer
//   item      start, busy, item_i     taken at a clock edge with start high, busy low
//   result    valid_o, result_o       held for one cycle, taken at the edge ending it
//
// Load, stop, set target, rejected and unknown items: the single result is issued in
// dispatch. A tick that does not advance and the first pattern of a play pass store
// read and evaluate; a tick that advances goes on through advance, store read and
// enter. Each further step of a chain passes advance, store read and enter, due to the
// step store's single registered read port. The next item can be taken at the edge
// that takes the last result. The step store is not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

`include "timed_step_sequencer_assert.svh"

module timed_step_sequencer
  import tss_pkg::*;
#(
  parameter int unsigned MaxSteps = MAX_STEPS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    valid_o,
  output result_t result_o
);

  cmd_t    cmd;
  status_t status;

  tss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  tss_datapath #(
    .MaxSteps (MaxSteps)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // A result never appears in the cycle after the block sat idle.
  `TSS_ASSERT_NEXT(a_no_result_after_idle, clk_i, rst_ni, !busy, !valid_o)
  // The last result of an item frees the block; earlier ones keep it busy.
  `TSS_ASSERT_NOW(a_last_frees, clk_i, rst_ni, valid_o, (result_o.last == !busy))
  // A status result carries pattern zero.
  `TSS_ASSERT_NOW(a_status_zero, clk_i, rst_ni, valid_o && !result_o.pattern_valid,
                  result_o.pattern == 8'd0)

endmodule

`default_nettype wire
